FILE: hdl/tlpc_pkg.sv
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants for the timed lift position control
// Holds the timer width, the command and position codes, the configuration
// register indexes and the packed words that travel on the ports.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  // Width of every timer and of the configuration data.
  localparam int TIME_BITS = 24;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // Reset values of the run-time registers, in microseconds.
  localparam time_t MIDDLE_TRAVEL_RESET = time_t'(1500000);
  localparam time_t LITTLE_DOWN_RESET   = time_t'(2500000);
  localparam time_t LITTLE_UP_RESET     = time_t'(580000);

  // Command codes carried in the mode field.
  typedef logic [2:0] mode_t;

  localparam mode_t MODE_TICK   = 3'd0;
  localparam mode_t MODE_HIGH   = 3'd1;
  localparam mode_t MODE_LOW    = 3'd2;
  localparam mode_t MODE_MIDDLE = 3'd3;
  localparam mode_t MODE_LITTLE = 3'd4;
  localparam mode_t MODE_OFF    = 3'd5;

  // Lift position codes.
  typedef logic [2:0] pos_t;

  localparam pos_t POS_UNKNOWN = 3'd0;
  localparam pos_t POS_HIGH    = 3'd1;
  localparam pos_t POS_LOW     = 3'd2;
  localparam pos_t POS_MIDDLE  = 3'd3;
  localparam pos_t POS_LITTLE  = 3'd4;

  // Kind of target for a timed move.
  localparam logic TARGET_MIDDLE = 1'b0;
  localparam logic TARGET_LITTLE = 1'b1;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_MIDDLE_TRAVEL = 2'd0;
  localparam cfg_index_t CFG_LITTLE_DOWN   = 2'd1;
  localparam cfg_index_t CFG_LITTLE_UP     = 2'd2;

  // Input word.
  typedef struct packed {
    mode_t mode;
    logic  halt;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic direction_down;
    logic motor_enable;
    pos_t position;
    logic moving;
  } out_word_t;

  // Current run-time settings handed from the register file to the core.
  typedef struct packed {
    time_t middle_travel_time;
    time_t little_down_time;
    time_t little_up_time;
  } cfg_times_t;

endpackage

FILE: hdl/timed_lift_position_control.sv
// ----------------------------------------------------------------------------
// timed_lift_position_control: lift motor pins and position tracking
// The block takes one word per cycle unless out_ready holds it and returns
// one registered result word for each. A word is accepted whenever the
// result register is empty or its word is being taken in the same cycle,
// so with out_ready held high the block sustains one word every cycle;
// the rate is set by the single state update between the input handshake
// and the result register. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module timed_lift_position_control import tlpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  time_t      cfg_data
);

  cfg_times_t times;
  out_word_t  result;
  logic       in_take;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;

  assign cfg_ready = 1'b1;

  tlpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .times    (times)
  );

  // Accept when the result register is free or draining this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  tlpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_take),
    .in_word (in_data),
    .times   (times),
    .result  (result)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/tlpc_cfg.sv
// ----------------------------------------------------------------------------
// tlpc_cfg: run-time configuration registers
// Three run-time registers, written through the configuration channel.
// Writes to an index beyond the list are taken and ignored.
// ----------------------------------------------------------------------------
module tlpc_cfg import tlpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cfg_index_t wr_index,
  input  time_t      wr_data,
  output cfg_times_t times
);

  cfg_times_t times_r;
  cfg_times_t times_nxt;

  // Select the register that a write lands in.
  always_comb begin
    times_nxt = times_r;
    if (wr_en) begin
      case (wr_index)
        CFG_MIDDLE_TRAVEL: times_nxt.middle_travel_time = wr_data;
        CFG_LITTLE_DOWN:   times_nxt.little_down_time   = wr_data;
        CFG_LITTLE_UP:     times_nxt.little_up_time     = wr_data;
        default:           times_nxt = times_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      times_r.middle_travel_time <= MIDDLE_TRAVEL_RESET;
      times_r.little_down_time   <= LITTLE_DOWN_RESET;
      times_r.little_up_time     <= LITTLE_UP_RESET;
    end else begin
      times_r <= times_nxt;
    end
  end

  assign times = times_r;

endmodule

FILE: hdl/tlpc_core.sv
// ----------------------------------------------------------------------------
// tlpc_core: lift state and command handling
// Holds the pin levels, the position and the timed-move timer, and works
// out the state after one accepted word in a single pass.
// ----------------------------------------------------------------------------
module tlpc_core import tlpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_word_t   in_word,
  input  cfg_times_t times,
  output out_word_t  result
);

  pos_t  position_r, position_nxt;
  logic  active_r, active_nxt;
  logic  kind_r, kind_nxt;
  time_t run_time_r, run_time_nxt;
  time_t elapsed_r, elapsed_nxt;
  logic  dir_r, dir_nxt;
  logic  enable_r, enable_nxt;

  time_t elapsed_inc;

  // Saturating timer increment.
  assign elapsed_inc = (elapsed_r != TIME_MAX) ? elapsed_r + time_t'(1) : elapsed_r;

  // Next state for one word.
  always_comb begin
    position_nxt = position_r;
    active_nxt   = active_r;
    kind_nxt     = kind_r;
    run_time_nxt = run_time_r;
    elapsed_nxt  = elapsed_r;
    dir_nxt      = dir_r;
    enable_nxt   = enable_r;
    if (in_word.halt) begin
      // A halt only cancels the timed move; the pins keep their levels.
      active_nxt = 1'b0;
    end else begin
      case (in_word.mode)
        MODE_TICK: begin
          if (active_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= run_time_r) begin
              dir_nxt      = 1'b0;
              enable_nxt   = 1'b0;
              active_nxt   = 1'b0;
              position_nxt = (kind_r == TARGET_LITTLE) ? POS_LITTLE : POS_MIDDLE;
            end
          end
        end
        MODE_HIGH: begin
          active_nxt   = 1'b0;
          dir_nxt      = 1'b0;
          enable_nxt   = 1'b1;
          position_nxt = POS_HIGH;
        end
        MODE_LOW: begin
          active_nxt   = 1'b0;
          dir_nxt      = 1'b1;
          enable_nxt   = 1'b1;
          position_nxt = POS_LOW;
        end
        MODE_MIDDLE: begin
          // From high the lift goes down, from anywhere else it goes up.
          dir_nxt      = (position_r == POS_HIGH);
          enable_nxt   = 1'b1;
          kind_nxt     = TARGET_MIDDLE;
          run_time_nxt = times.middle_travel_time;
          elapsed_nxt  = '0;
          active_nxt   = 1'b1;
        end
        MODE_LITTLE: begin
          kind_nxt    = TARGET_LITTLE;
          elapsed_nxt = '0;
          active_nxt  = 1'b1;
          if (position_r == POS_HIGH) begin
            dir_nxt      = 1'b1;
            enable_nxt   = 1'b1;
            run_time_nxt = times.little_down_time;
          end else if (position_r == POS_LOW) begin
            dir_nxt      = 1'b0;
            enable_nxt   = 1'b1;
            run_time_nxt = times.little_up_time;
          end else begin
            // Any other start (unknown, middle or little): pins untouched, the next tick ends the move.
            run_time_nxt = '0;
          end
        end
        MODE_OFF: begin
          active_nxt = 1'b0;
          dir_nxt    = 1'b0;
          enable_nxt = 1'b0;
        end
        default: begin
          // Unused codes leave the state alone.
          active_nxt = active_r;
        end
      endcase
    end
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= POS_UNKNOWN;
      active_r   <= 1'b0;
      kind_r     <= TARGET_MIDDLE;
      run_time_r <= '0;
      elapsed_r  <= '0;
      dir_r      <= 1'b0;
      enable_r   <= 1'b0;
    end else if (step) begin
      position_r <= position_nxt;
      active_r   <= active_nxt;
      kind_r     <= kind_nxt;
      run_time_r <= run_time_nxt;
      elapsed_r  <= elapsed_nxt;
      dir_r      <= dir_nxt;
      enable_r   <= enable_nxt;
    end
  end

  // The result shows the state after the word has been handled.
  assign result.direction_down = dir_nxt;
  assign result.motor_enable   = enable_nxt;
  assign result.position       = position_nxt;
  assign result.moving         = active_nxt;

endmodule
